// ===== rtl/go_back_n_sender_core_defines.svh =====
// Assertion helpers shared by the sender RTL.
// Both expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef GO_BACK_N_SENDER_CORE_DEFINES_SVH
`define GO_BACK_N_SENDER_CORE_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequent holds in the cycle after an antecedent.
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gbn_pkg.sv =====
package gbn_pkg;

  localparam int SEQ_W    = 4;
  localparam int SEQ_SPACE = 1 << SEQ_W;
  localparam int HANDLE_W = 16;
  localparam int LEN_W    = 8;
  localparam int SLOT_W   = HANDLE_W + LEN_W;
  localparam int WIN_W    = 4;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int TIMER_W  = 2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(7);
  localparam logic [LEN_W-1:0] MAX_PAYLOAD  = LEN_W'(255);

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_SEND    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ACK     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TIMEOUT = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_SENT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACK_OK    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ACK_IGN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RESEND    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TO_EMPTY  = 3'd5;

  // Timer commands
  localparam logic [TIMER_W-1:0] TMR_NONE  = 2'd0;
  localparam logic [TIMER_W-1:0] TMR_START = 2'd1;
  localparam logic [TIMER_W-1:0] TMR_STOP  = 2'd2;

  // Classified command from the front end to the back end
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq;     // packet number, or window base for a resend
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    length;
    logic [TIMER_W-1:0]  timer;
    logic [SEQ_W-1:0]    base;
    logic [SEQ_W-1:0]    next;
    logic [SEQ_W-1:0]    count;   // packets to resend
  } gbn_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                emit_valid;
    logic [SEQ_W-1:0]    packet_seq;
    logic [HANDLE_W-1:0] packet_handle;
    logic [LEN_W-1:0]    packet_length;
    logic [TIMER_W-1:0]  timer_cmd;
    logic [SEQ_W-1:0]    window_base;
    logic [SEQ_W-1:0]    next_seq;
    logic                last;
  } gbn_res_t;

endpackage

// ===== rtl/gbn_in_if.sv =====
interface gbn_in_if;
  import gbn_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [HANDLE_W-1:0] payload_handle;
  logic [LEN_W-1:0]    payload_length;
  logic [SEQ_W-1:0]    ack_seq;
  logic                ack_ok;

  modport source (
    output valid, action, payload_handle, payload_length, ack_seq, ack_ok,
    input  ready
  );
  modport sink (
    input  valid, action, payload_handle, payload_length, ack_seq, ack_ok,
    output ready
  );
endinterface

// ===== rtl/gbn_out_if.sv =====
interface gbn_out_if;
  import gbn_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                emit_valid;
  logic [SEQ_W-1:0]    packet_seq;
  logic [HANDLE_W-1:0] packet_handle;
  logic [LEN_W-1:0]    packet_length;
  logic [TIMER_W-1:0]  timer_cmd;
  logic [SEQ_W-1:0]    window_base;
  logic [SEQ_W-1:0]    next_seq;
  logic                last;

  modport source (
    output valid, status, emit_valid, packet_seq, packet_handle, packet_length,
           timer_cmd, window_base, next_seq, last,
    input  ready
  );
  modport sink (
    input  valid, status, emit_valid, packet_seq, packet_handle, packet_length,
           timer_cmd, window_base, next_seq, last,
    output ready
  );
endinterface

// ===== rtl/gbn_cfg_if.sv =====
interface gbn_cfg_if;
  import gbn_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window_size;

  modport source (output valid, window_size, input ready);
  modport sink (input valid, window_size, output ready);
endinterface

// ===== rtl/gbn_queue.sv =====
module gbn_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gbn_pkg::gbn_cmd_t cmd_i,
  output logic              full_o,
  output logic              valid_o,
  output gbn_pkg::gbn_cmd_t cmd_o,
  input  logic              pop_i
);
  import gbn_pkg::*;

  gbn_cmd_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ===== rtl/gbn_front.sv =====
module gbn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  gbn_in_if.sink            in_ch,
  gbn_cfg_if.sink           cfg_ch,
  input  logic              q_full_i,
  output logic              q_push_o,
  output gbn_pkg::gbn_cmd_t q_cmd_o
);
  import gbn_pkg::*;

  logic [WIN_W-1:0] window_q;
  logic [SEQ_W-1:0] base_q, base_d, next_q, next_d;
  logic [SEQ_W-1:0] outst, ack_dist;
  logic             accept;
  logic             classified;
  gbn_cmd_t         cmd;

  assign in_ch.ready  = !q_full_i;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;

  // Distances wrap with the sequence space
  assign outst    = next_q - base_q;
  assign ack_dist = in_ch.ack_seq - base_q;

  always_comb begin
    cmd        = '0;
    base_d     = base_q;
    next_d     = next_q;
    classified = 1'b1;
    unique case (in_ch.action)
      ACT_SEND: begin
        if (outst >= window_q) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.status = ST_SENT;
          cmd.seq    = next_q;
          cmd.handle = in_ch.payload_handle;
          cmd.length = (in_ch.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                            : in_ch.payload_length;
          cmd.timer  = (outst == '0) ? TMR_START : TMR_NONE;
          next_d     = next_q + SEQ_W'(1);
        end
      end
      ACT_ACK: begin
        if (in_ch.ack_ok && (ack_dist < outst)) begin
          base_d     = in_ch.ack_seq + SEQ_W'(1);
          cmd.status = ST_ACK_OK;
          cmd.timer  = (base_d == next_q) ? TMR_STOP : TMR_START;
        end else begin
          cmd.status = ST_ACK_IGN;
        end
      end
      ACT_TIMEOUT: begin
        if (outst == '0) begin
          cmd.status = ST_TO_EMPTY;
        end else begin
          cmd.status = ST_RESEND;
          cmd.seq    = base_q;
          cmd.count  = outst;
        end
      end
      default: begin
        // unknown action: drop without a result
        classified = 1'b0;
      end
    endcase
    cmd.base = base_d;
    cmd.next = next_d;
  end

  assign q_push_o = accept && classified;
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      base_q   <= '0;
      next_q   <= '0;
    end else begin
      if (cfg_ch.valid) begin
        window_q <= cfg_ch.window_size;
      end
      if (accept) begin
        base_q <= base_d;
        next_q <= next_d;
      end
    end
  end
endmodule

// ===== rtl/gbn_back.sv =====
`include "go_back_n_sender_core_defines.svh"

module gbn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  gbn_pkg::gbn_cmd_t q_cmd_i,
  output logic              q_pop_o,
  gbn_out_if.source         out_ch
);
  import gbn_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] mem_q [SEQ_SPACE];
  logic [SLOT_W-1:0] rd_data_q;
  logic [SEQ_W-1:0]  rs_base_q, rs_cnt_q, rs_idx_q, rs_idx_d;
  logic [SEQ_W-1:0]  rs_wbase_q, rs_wnext_q;
  logic [SEQ_W-1:0]  rs_seq;
  logic              rs_last;
  gbn_res_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              pop;
  logic              mem_we, mem_re;

  assign out_free = !out_valid_q || out_ch.ready;
  assign pop      = (state_q == S_IDLE) && q_valid_i && out_free;
  assign q_pop_o  = pop;
  assign rs_seq   = rs_base_q + rs_idx_q;
  assign rs_last  = (rs_idx_q + SEQ_W'(1)) == rs_cnt_q;
  assign mem_we   = pop && (q_cmd_i.status == ST_SENT);
  assign mem_re   = (state_q == S_READ);

  always_comb begin
    state_d     = state_q;
    rs_idx_d    = rs_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          if (q_cmd_i.status == ST_RESEND) begin
            rs_idx_d = '0;
            state_d  = S_READ;
          end else begin
            out_d.status        = q_cmd_i.status;
            out_d.emit_valid    = (q_cmd_i.status == ST_SENT);
            out_d.packet_seq    = q_cmd_i.seq;
            out_d.packet_handle = q_cmd_i.handle;
            out_d.packet_length = q_cmd_i.length;
            out_d.timer_cmd     = q_cmd_i.timer;
            out_d.window_base   = q_cmd_i.base;
            out_d.next_seq      = q_cmd_i.next;
            out_d.last          = 1'b1;
            out_valid_d         = 1'b1;
          end
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_d.status        = ST_RESEND;
          out_d.emit_valid    = 1'b1;
          out_d.packet_seq    = rs_seq;
          out_d.packet_handle = rd_data_q[HANDLE_W-1:0];
          out_d.packet_length = rd_data_q[SLOT_W-1:HANDLE_W];
          out_d.timer_cmd     = (rs_idx_q == '0) ? TMR_START : TMR_NONE;
          out_d.window_base   = rs_wbase_q;
          out_d.next_seq      = rs_wnext_q;
          out_d.last          = rs_last;
          out_valid_d         = 1'b1;
          rs_idx_d            = rs_idx_q + SEQ_W'(1);
          state_d             = rs_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Slot memory: written on a send, read one slot per resend step
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[q_cmd_i.seq] <= {q_cmd_i.length, q_cmd_i.handle};
    end
    if (mem_re) begin
      rd_data_q <= mem_q[rs_seq];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (pop) begin
      rs_base_q  <= q_cmd_i.seq;
      rs_cnt_q   <= q_cmd_i.count;
      rs_wbase_q <= q_cmd_i.base;
      rs_wnext_q <= q_cmd_i.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rs_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rs_idx_q    <= rs_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.status        = out_q.status;
  assign out_ch.emit_valid    = out_q.emit_valid;
  assign out_ch.packet_seq    = out_q.packet_seq;
  assign out_ch.packet_handle = out_q.packet_handle;
  assign out_ch.packet_length = out_q.packet_length;
  assign out_ch.timer_cmd     = out_q.timer_cmd;
  assign out_ch.window_base   = out_q.window_base;
  assign out_ch.next_seq      = out_q.next_seq;
  assign out_ch.last          = out_q.last;

  `GBN_ASSERT(a_rs_idx_in_range, (state_q == S_IDLE) || (rs_idx_q < rs_cnt_q), "resend index past count")
  `GBN_ASSERT_NEXT(a_read_then_emit, state_q == S_READ, state_q == S_EMIT, "slot read not followed by emit")
  `GBN_ASSERT(a_resend_not_done, !(out_valid_q && (out_q.status == ST_RESEND) && !out_q.last) || (state_q != S_IDLE), "resend burst ended early")
endmodule

// ===== rtl/go_back_n_sender_core.sv =====
// Channel  | Dir | Handshake   | Payload
// in_ch    | in  | valid/ready | action, payload_handle, payload_length, ack_seq, ack_ok
// out_ch   | out | valid/ready | status, emit_valid, packet_*, timer_cmd, window_base,
//          |     |             | next_seq, last
// cfg_ch   | in  | valid/ready | window_size (always ready)
//
// Send, ack and timeout-with-empty-window items give one result each, one item per cycle
// while the two-entry command queue has room.
// A timeout resend passes S_READ and S_EMIT per outstanding packet: one slot memory read
// and one output register load per packet, on the single read port of the slot memory.
// Output stalls back up through the queue to in_ch.ready; reset clears control state.
module go_back_n_sender_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbn_in_if.sink    in_ch,
  gbn_cfg_if.sink   cfg_ch,
  gbn_out_if.source out_ch
);
  import gbn_pkg::*;

  logic     q_full, q_push, q_valid, q_pop;
  gbn_cmd_t push_cmd, head_cmd;

  gbn_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  gbn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (q_pop)
  );

  gbn_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (head_cmd),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );
endmodule
